/* rtl/mrm_pkg.sv */
// Shared types and constants for the modulation route matrix.
// Used by mrm_ctrl, mrm_dp and modulation_route_matrix; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrm_pkg;

    localparam int ROUTE_COUNT_DEF = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SRC_W      = 4;
    localparam int SLOT_W     = 8;
    localparam int DEPTH_W    = 16;
    localparam int IDX_OUT_W  = 4;
    localparam int MOD_W      = 20;
    localparam int SMP_IDX_W  = 4;

    localparam int SOURCE_COUNT   = 12;
    localparam int DEPTH_DEADBAND = 655;   // 0.02 in Q1.15
    localparam int MOD_MAX        = 524287;
    localparam int MOD_MIN        = -524288;
    localparam int FRAC_BITS      = 15;

    localparam logic [SRC_W-1:0] SRC_OFF = 4'd0;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_CLEAN  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } mrm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture transaction fields, clear search/accumulator
        logic scan;    // read route at scan counter, advance counter
        logic finish;  // commit writes and register the result
    } mrm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;  // scan counter points at the last route
        logic pipe_busy;  // read or multiply stage still holds data
    } mrm_stat_t;

endpackage

`default_nettype wire

/* rtl/modulation_route_matrix.sv */
// Top level of the modulation route matrix.
// Depends on mrm_pkg, mrm_ctrl and mrm_dp.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   opcode selects route update, source sample load, slot query or cleanup,
//   and the other input fields are sampled in the same edge.
//   Exactly one result follows per transaction: route_index, table_full and
//   modulation are valid for the single cycle in which done is high. The
//   receiver cannot stall the block; done is a one-cycle strobe.
//   A sample load goes from acceptance straight to the finish state. Update,
//   query and cleanup walk the route memory one route per cycle, then wait
//   for the read and multiply stages to drain before the finish state; done
//   follows the finish state. busy drops in the cycle done is high, so a new
//   transaction may be taken in that cycle; transactions never overlap, and
//   the route scan through the single read port of the route memory paces
//   route transactions.
//   Reset (rst_n low, asynchronous) clears all routes through per-route
//   valid bits and zeroes all source samples; no clearing pass is needed.
module modulation_route_matrix
    import mrm_pkg::*;
#(
    parameter int ROUTE_COUNT = ROUTE_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                opcode,
    input  wire logic [SRC_W-1:0]          route_source,
    input  wire logic [SLOT_W-1:0]         slot,
    input  wire logic signed [DEPTH_W-1:0] amount,
    input  wire logic [SRC_W-1:0]          sample_source,
    input  wire logic signed [DEPTH_W-1:0] sample_value,
    output logic                           done,
    output logic [IDX_OUT_W-1:0]           route_index,
    output logic                           table_full,
    output logic signed [MOD_W-1:0]        modulation
);

    mrm_cmd_t  cmd;
    mrm_stat_t stat;

    mrm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    mrm_dp #(
        .ROUTE_COUNT (ROUTE_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .route_source  (route_source),
        .slot          (slot),
        .amount        (amount),
        .sample_source (sample_source),
        .sample_value  (sample_value),
        .done          (done),
        .route_index   (route_index),
        .table_full    (table_full),
        .modulation    (modulation)
    );

endmodule

`default_nettype wire

/* rtl/mrm_ctrl.sv */
// Sequencer for the modulation route matrix: accept, scan, drain, finish.
// Depends on mrm_pkg; drives mrm_dp through mrm_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module mrm_ctrl
    import mrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    input  wire mrm_stat_t  stat,
    output mrm_cmd_t        cmd,
    output logic            busy
);

    mrm_state_t state_reg;
    mrm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    // a sample load touches no route
                    state_next = (opcode == OP_LOAD) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_fin_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> state_reg == ST_IDLE)
        else $error("finish did not return to idle");

    a_load_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && opcode == OP_LOAD) |=> state_reg == ST_FIN)
        else $error("sample load entered route scan");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stat.scan_last) |=> state_reg == ST_DRAIN)
        else $error("scan ran past last route");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && opcode != OP_LOAD) |=> state_reg == ST_SCAN)
        else $error("route transaction did not start scan");

endmodule

`default_nettype wire

/* rtl/mrm_dp.sv */
// Datapath for the modulation route matrix: route memory with valid bits,
// source samples, match/free search, multiply-accumulate and result regs.
// Depends on mrm_pkg; sequenced by mrm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mrm_dp
    import mrm_pkg::*;
#(
    parameter int ROUTE_COUNT = ROUTE_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mrm_cmd_t                  cmd,
    output mrm_stat_t                      stat,
    input  wire logic [1:0]                opcode,
    input  wire logic [SRC_W-1:0]          route_source,
    input  wire logic [SLOT_W-1:0]         slot,
    input  wire logic signed [DEPTH_W-1:0] amount,
    input  wire logic [SRC_W-1:0]          sample_source,
    input  wire logic signed [DEPTH_W-1:0] sample_value,
    output logic                           done,
    output logic [IDX_OUT_W-1:0]           route_index,
    output logic                           table_full,
    output logic signed [MOD_W-1:0]        modulation
);

    localparam int RIDX_W  = (ROUTE_COUNT > 1) ? $clog2(ROUTE_COUNT) : 1;
    localparam int RW      = SRC_W + SLOT_W + DEPTH_W;
    localparam int PROD_W  = SAMPLE_BITS + DEPTH_W;
    localparam int ACC_RAW = PROD_W + $clog2(ROUTE_COUNT) + 1;
    localparam int ACC_W   = (ACC_RAW > 36) ? ACC_RAW : 36;

    // captured transaction fields
    logic [1:0]                op_reg;
    logic [SRC_W-1:0]          src_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic signed [DEPTH_W-1:0] amt_reg;
    logic [SRC_W-1:0]          ssrc_reg;
    logic signed [DEPTH_W-1:0] sval_reg;

    logic [RW-1:0]          route_mem [ROUTE_COUNT];
    logic [ROUTE_COUNT-1:0] route_vld_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg [SOURCE_COUNT];

    logic [RIDX_W-1:0] scan_cnt_reg;
    logic [RW-1:0]     rd_word_reg;
    logic              rd_ok_reg;
    logic              rd_vld_reg;
    logic [RIDX_W-1:0] rd_idx_reg;

    logic              match_found_reg;
    logic              free_found_reg;
    logic [RIDX_W-1:0] match_idx_reg;
    logic [RIDX_W-1:0] free_idx_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                        done_reg;
    logic [IDX_OUT_W-1:0]        route_index_reg;
    logic [IDX_OUT_W-1:0]        route_index_next;
    logic                        table_full_reg;
    logic                        table_full_next;
    logic signed [MOD_W-1:0]     modulation_reg;
    logic signed [MOD_W-1:0]     modulation_next;

    logic [RW-1:0]                 rd_word;
    logic [SRC_W-1:0]              rd_src;
    logic [SLOT_W-1:0]             rd_slot;
    logic signed [DEPTH_W-1:0]     rd_depth;
    logic                          src_live;
    logic                          q_hit;
    logic [SMP_IDX_W-1:0]          smp_idx;
    logic signed [SAMPLE_BITS-1:0] smp_val;
    logic signed [DEPTH_W-1:0]     amt_db;
    logic                          found;
    logic [RIDX_W-1:0]             hit_idx;
    logic                          mem_we;
    logic [RIDX_W-1:0]             mem_waddr;
    logic [RW-1:0]                 mem_wdata;
    logic signed [ACC_W-1:0]       acc_sh;
    logic signed [ACC_W-1:0]       mod_hi;
    logic signed [ACC_W-1:0]       mod_lo;
    logic                          smp_wr;

    // read stage decode; never-written routes read as reset value
    always_comb
    begin
        rd_word  = rd_ok_reg ? rd_word_reg : '0;
        rd_src   = rd_word[RW-1 -: SRC_W];
        rd_slot  = rd_word[DEPTH_W +: SLOT_W];
        rd_depth = rd_word[DEPTH_W-1:0];
        src_live = (rd_src != SRC_OFF) && (rd_src <= SRC_W'(SOURCE_COUNT));
        q_hit    = src_live && (rd_slot == slot_reg);
        smp_idx  = SMP_IDX_W'(rd_src - SRC_W'(1));
        smp_val  = src_live ? sample_reg[smp_idx] : '0;
    end

    always_comb
    begin
        if ((amt_reg > -DEPTH_DEADBAND) && (amt_reg < DEPTH_DEADBAND))
        begin
            amt_db = '0;
        end
        else
        begin
            amt_db = amt_reg;
        end
        found   = match_found_reg || free_found_reg;
        hit_idx = match_found_reg ? match_idx_reg : free_idx_reg;
        smp_wr  = cmd.finish && (op_reg == OP_LOAD) && (ssrc_reg != SRC_OFF)
                  && (ssrc_reg <= SRC_W'(SOURCE_COUNT));
    end

    // single write port: update commit at finish, cleanup write-back from the read stage
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = {SRC_OFF, rd_slot, rd_depth};
        priority if (cmd.finish && (op_reg == OP_UPDATE) && found)
        begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx;
            mem_wdata = {src_reg, slot_reg, amt_db};
        end
        else if (rd_vld_reg && (op_reg == OP_CLEAN) && (rd_depth == '0))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            route_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan)
        begin
            rd_word_reg <= route_mem[scan_cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            src_reg  <= route_source;
            slot_reg <= slot;
            amt_reg  <= amount;
            ssrc_reg <= sample_source;
            sval_reg <= sample_value;
        end
        if (rd_vld_reg || cmd.scan)
        begin
            rd_idx_reg <= scan_cnt_reg;
        end
        if (rd_vld_reg && (op_reg == OP_UPDATE))
        begin
            if (!match_found_reg && (rd_src == src_reg) && (rd_slot == slot_reg))
            begin
                match_idx_reg <= rd_idx_reg;
            end
            if (!free_found_reg && ((rd_src == SRC_OFF) || (rd_depth == '0)))
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if ((op_reg == OP_QUERY) && q_hit)
        begin
            prod_reg <= smp_val * rd_depth;
        end
        else
        begin
            prod_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_vld_reg   <= '0;
            scan_cnt_reg    <= '0;
            rd_ok_reg       <= 1'b0;
            rd_vld_reg      <= 1'b0;
            prod_vld_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            acc_reg         <= '0;
            for (int i = 0; i < SOURCE_COUNT; i++)
            begin
                sample_reg[i] <= '0;
            end
        end
        else
        begin
            if (mem_we)
            begin
                route_vld_reg[mem_waddr] <= 1'b1;
            end
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_cnt_reg <= scan_cnt_reg + RIDX_W'(1);
            end
            if (cmd.scan)
            begin
                rd_ok_reg <= route_vld_reg[scan_cnt_reg];
            end
            rd_vld_reg   <= cmd.scan;
            prod_vld_reg <= rd_vld_reg;
            if (cmd.load)
            begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else if (rd_vld_reg && (op_reg == OP_UPDATE))
            begin
                if ((rd_src == src_reg) && (rd_slot == slot_reg))
                begin
                    match_found_reg <= 1'b1;
                end
                if ((rd_src == SRC_OFF) || (rd_depth == '0))
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.load)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (smp_wr)
            begin
                sample_reg[SMP_IDX_W'(ssrc_reg - SRC_W'(1))] <= SAMPLE_BITS'(sval_reg);
            end
        end
    end

    // query: floor shift then saturate to the result width; update: index or full flag
    always_comb
    begin
        mod_hi = ACC_W'(MOD_MAX);
        mod_lo = ACC_W'(MOD_MIN);
        acc_sh = acc_reg >>> FRAC_BITS;
        route_index_next = '0;
        table_full_next  = 1'b0;
        modulation_next  = '0;
        unique case (op_reg)
            OP_UPDATE:
            begin
                if (found)
                begin
                    route_index_next = IDX_OUT_W'(hit_idx);
                end
                else
                begin
                    table_full_next = 1'b1;
                end
            end
            OP_QUERY:
            begin
                priority if (acc_sh > mod_hi)
                begin
                    modulation_next = MOD_W'(MOD_MAX);
                end
                else if (acc_sh < mod_lo)
                begin
                    modulation_next = MOD_W'(MOD_MIN);
                end
                else
                begin
                    modulation_next = acc_sh[MOD_W-1:0];
                end
            end
            OP_LOAD, OP_CLEAN:
            begin
                modulation_next = '0;
            end
            default:
            begin
                modulation_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            route_index_reg <= '0;
            table_full_reg  <= 1'b0;
            modulation_reg  <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                route_index_reg <= route_index_next;
                table_full_reg  <= table_full_next;
                modulation_reg  <= modulation_next;
            end
        end
    end

    assign stat.scan_last = (scan_cnt_reg == RIDX_W'(ROUTE_COUNT - 1));
    assign stat.pipe_busy = rd_vld_reg || prod_vld_reg;

    assign done        = done_reg;
    assign route_index = route_index_reg;
    assign table_full  = table_full_reg;
    assign modulation  = modulation_reg;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_full_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && table_full_reg) |-> (route_index_reg == '0 && modulation_reg == '0))
        else $error("full flag with nonzero result fields");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.finish && !rd_vld_reg) |-> !mem_we)
        else $error("route write outside scan or finish");

endmodule

`default_nettype wire

/* tb/mrm_route_sb_pkg.sv */
// Scoreboard for the modulation route matrix testbench: route table predictor and result check.
// Depends on mrm_pkg for field widths and opcodes.
`timescale 1ns / 1ps

package mrm_route_sb_pkg;

    import mrm_pkg::*;

    typedef struct {
        logic [1:0]                op;
        logic [SRC_W-1:0]          route_source;
        logic [SLOT_W-1:0]         slot;
        logic signed [DEPTH_W-1:0] amount;
        logic [SMP_IDX_W-1:0]      sample_source;
        logic signed [DEPTH_W-1:0] sample_value;
    } route_cmd_t;

    typedef struct {
        logic [IDX_OUT_W-1:0]    route_index;
        logic                    table_full;
        logic signed [MOD_W-1:0] modulation;
    } mix_reply_t;

    class route_matrix_scoreboard;
        logic [SRC_W-1:0]          src_tbl   [ROUTE_COUNT_DEF];
        logic [SLOT_W-1:0]         slot_tbl  [ROUTE_COUNT_DEF];
        logic signed [DEPTH_W-1:0] depth_tbl [ROUTE_COUNT_DEF];
        logic signed [DEPTH_W-1:0] samples   [SOURCE_COUNT];
        mix_reply_t                mix_replies [$];
        int                        error_count;

        function new();
            for (int i = 0; i < ROUTE_COUNT_DEF; i++)
            begin
                src_tbl[i]   = SRC_OFF;
                slot_tbl[i]  = '0;
                depth_tbl[i] = '0;
            end
            for (int i = 0; i < SOURCE_COUNT; i++)
                samples[i] = '0;
            error_count = 0;
        endfunction

        function int pending();
            return mix_replies.size();
        endfunction

        // Advance the route table and source samples by one accepted transaction and queue its reply.
        function void note_command(route_cmd_t c);
            mix_reply_t                r;
            logic signed [DEPTH_W-1:0] d;
            int                        hit;
            longint                    acc;
            longint                    res;
            r.route_index = '0;
            r.table_full  = 1'b0;
            r.modulation  = '0;
            case (c.op)
                OP_UPDATE:
                begin
                    d = c.amount;
                    if (d > -DEPTH_DEADBAND && d < DEPTH_DEADBAND)
                        d = '0;
                    hit = -1;
                    for (int i = 0; i < ROUTE_COUNT_DEF; i++)
                        if (hit < 0 && src_tbl[i] == c.route_source && slot_tbl[i] == c.slot)
                            hit = i;
                    for (int i = 0; i < ROUTE_COUNT_DEF; i++)
                        if (hit < 0 && (src_tbl[i] == SRC_OFF || depth_tbl[i] == 0))
                            hit = i;
                    if (hit >= 0)
                    begin
                        src_tbl[hit]   = c.route_source;
                        slot_tbl[hit]  = c.slot;
                        depth_tbl[hit] = d;
                        r.route_index  = hit[IDX_OUT_W-1:0];
                    end
                    else
                        r.table_full = 1'b1;
                end
                OP_LOAD:
                begin
                    if (c.sample_source >= 1 && c.sample_source <= SOURCE_COUNT)
                        samples[int'(c.sample_source) - 1] = c.sample_value;
                end
                OP_QUERY:
                begin
                    acc = 0;
                    for (int i = 0; i < ROUTE_COUNT_DEF; i++)
                        if (slot_tbl[i] == c.slot && src_tbl[i] >= 1 && src_tbl[i] <= SOURCE_COUNT)
                            acc += longint'(samples[int'(src_tbl[i]) - 1])
                                 * longint'(depth_tbl[i]);
                    res = acc >>> FRAC_BITS;   // floor
                    if (res > MOD_MAX)
                        res = MOD_MAX;
                    if (res < MOD_MIN)
                        res = MOD_MIN;
                    r.modulation = res[MOD_W-1:0];
                end
                default:
                begin
                    for (int i = 0; i < ROUTE_COUNT_DEF; i++)
                        if (depth_tbl[i] == 0)
                            src_tbl[i] = SRC_OFF;
                end
            endcase
            mix_replies.push_back(r);
        endfunction

        function void check_result(logic [IDX_OUT_W-1:0] idx, logic full,
                                   logic signed [MOD_W-1:0] modv);
            mix_reply_t r;
            if (mix_replies.size() == 0)
            begin
                $error("result with no transaction outstanding");
                error_count++;
                return;
            end
            r = mix_replies.pop_front();
            if (idx !== r.route_index)
            begin
                $error("route_index: expected %0d, actual %0d", r.route_index, idx);
                error_count++;
            end
            if (full !== r.table_full)
            begin
                $error("table_full: expected %0d, actual %0d", r.table_full, full);
                error_count++;
            end
            if (modv !== r.modulation)
            begin
                $error("modulation: expected %0d, actual %0d", r.modulation, modv);
                error_count++;
            end
        endfunction
    endclass

endpackage

/* tb/tb_modulation_route_matrix.sv */
// Top-level testbench for modulation_route_matrix: directed and random transactions.
// Depends on mrm_pkg, mrm_route_sb_pkg and the modulation_route_matrix RTL.
`timescale 1ns / 1ps

module tb_modulation_route_matrix;

    import mrm_pkg::*;
    import mrm_route_sb_pkg::*;

    localparam int RANDOM_TXNS = 1450;
    localparam int TAIL_CYCLES = ROUTE_COUNT_DEF + 24;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                opcode;
    logic [SRC_W-1:0]          route_source;
    logic [SLOT_W-1:0]         slot;
    logic signed [DEPTH_W-1:0] amount;
    logic [SMP_IDX_W-1:0]      sample_source;
    logic signed [DEPTH_W-1:0] sample_value;
    logic                      done;
    logic [IDX_OUT_W-1:0]      route_index;
    logic                      table_full;
    logic signed [MOD_W-1:0]   modulation;

    route_matrix_scoreboard sb = new();

    modulation_route_matrix i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .route_source  (route_source),
        .slot          (slot),
        .amount        (amount),
        .sample_source (sample_source),
        .sample_value  (sample_value),
        .done          (done),
        .route_index   (route_index),
        .table_full    (table_full),
        .modulation    (modulation)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(route_index, table_full, modulation);
    end

    initial
    begin
        #5_000_000;
        $display("tb_modulation_route_matrix: done, errors");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue_command(input route_cmd_t c);
        opcode        <= c.op;
        route_source  <= c.route_source;
        slot          <= c.slot;
        amount        <= c.amount;
        sample_source <= c.sample_source;
        sample_value  <= c.sample_value;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c);
        @(negedge clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic route_cmd_t make_cmd(logic [1:0] op, int src, int sl, int amt,
                                            int ssrc, int sval);
        route_cmd_t c;
        c.op            = op;
        c.route_source  = src[SRC_W-1:0];
        c.slot          = sl[SLOT_W-1:0];
        c.amount        = amt[DEPTH_W-1:0];
        c.sample_source = ssrc[SMP_IDX_W-1:0];
        c.sample_value  = sval[DEPTH_W-1:0];
        return c;
    endfunction

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic route_cmd_t random_command();
        route_cmd_t c;
        int         p;
        p = $urandom_range(0, 99);
        if (p < 35)
            c.op = OP_UPDATE;
        else if (p < 60)
            c.op = OP_LOAD;
        else if (p < 90)
            c.op = OP_QUERY;
        else
            c.op = OP_CLEAN;
        // keep most routes on a handful of slots so queries and matches hit
        p = $urandom_range(0, 99);
        if (p < 70)
            c.slot = SLOT_W'($urandom_range(0, 3));
        else if (p < 80)
            c.slot = 8'd255;
        else
            c.slot = SLOT_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
            c.route_source = SRC_W'($urandom_range(1, SOURCE_COUNT));
        else
            c.route_source = SRC_W'($urandom_range(0, 15));
        p = $urandom_range(0, 99);
        if (p < 20)
            c.amount = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        else if (p < 45)
            c.amount = DEPTH_W'($urandom_range(0, 1400) - 700);   // around the dead band
        else
            c.amount = DEPTH_W'($urandom);
        c.sample_source = SMP_IDX_W'($urandom_range(0, 15));
        p = $urandom_range(0, 99);
        if (p < 15)
            c.sample_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        else
            c.sample_value = DEPTH_W'($urandom);
        return c;
    endfunction

    initial
    begin
        bit gaps_on;
        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_UPDATE;
        route_source  = SRC_OFF;
        slot          = '0;
        amount        = '0;
        sample_source = '0;
        sample_value  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full-scale samples on every source, one route per source on slot 255
        for (int s = 1; s <= SOURCE_COUNT; s++)
            issue_command(make_cmd(OP_LOAD, 0, 0, 0, s, (s == 2) ? 32767 : -32768));
        for (int s = 1; s <= SOURCE_COUNT; s++)
            issue_command(make_cmd(OP_UPDATE, s, 255, (s == 1) ? 32767 : -32768, 0, 0));
        issue_command(make_cmd(OP_QUERY, 0, 255, 0, 0, 0));
        // dead band edges, sources past 12, source off, every route written once, then a cleanup
        issue_command(make_cmd(OP_UPDATE, 13, 255, 654, 0, 0));
        issue_command(make_cmd(OP_UPDATE, 0, 255, -655, 0, 0));
        issue_command(make_cmd(OP_UPDATE, 15, 9, 655, 0, 0));
        issue_command(make_cmd(OP_UPDATE, 14, 255, -32768, 0, 0));
        issue_command(make_cmd(OP_UPDATE, 13, 255, 700, 0, 0));
        issue_command(make_cmd(OP_UPDATE, 5, 9, 1000, 0, 0));
        issue_command(make_cmd(OP_UPDATE, 1, 255, -654, 0, 0));
        issue_command(make_cmd(OP_CLEAN, 0, 0, 0, 0, 0));
        issue_command(make_cmd(OP_UPDATE, 0, 255, 30000, 0, 0));
        issue_command(make_cmd(OP_QUERY, 0, 255, 0, 0, 0));
        drain_results();

        gaps_on = 1'b1;
        for (int n = 0; n < RANDOM_TXNS; n++)
        begin
            if (n % 100 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (n % 250 == 125)
                drain_results();
            else if (gaps_on)
                idle_for(random_gap());
            issue_command(random_command());
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("tb_modulation_route_matrix: done, clean");
        else
            $display("tb_modulation_route_matrix: done, errors");
        $finish;
    end

endmodule
